// ----- sv/r2f_pkg.sv -----
// Package for the RGB565 to 2bpp frame writer: payload structs, register
// indexes, panel codes and the color conversion functions.
// No dependencies.
package r2f_pkg;

   localparam int COORD_W     = 12;
   localparam int PIXEL_W     = 16;
   localparam int RIDX_W      = 15;
   localparam int BYTE_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam int PANEL_WIDTH_DEF  = 400;
   localparam int PANEL_HEIGHT_DEF = 300;

   localparam logic signed [COORD_W-1:0] AREA_LEFT_RST   = 12'sd0;
   localparam logic signed [COORD_W-1:0] AREA_TOP_RST    = 12'sd0;
   localparam logic signed [COORD_W-1:0] AREA_RIGHT_RST  = 12'sd399;
   localparam logic signed [COORD_W-1:0] AREA_BOTTOM_RST = 12'sd299;

   localparam logic [BYTE_W-1:0] WHITE_BYTE = 8'h55;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // ceil(2^20 / 31) and ceil(2^20 / 63), exact for the products used here
   localparam logic [15:0] RECIP31 = 16'd33826;
   localparam logic [15:0] RECIP63 = 16'd16645;

   localparam logic [7:0] LUMA_DARK  = 8'd64;
   localparam logic [7:0] LUMA_MID   = 8'd128;
   localparam logic [7:0] LUMA_LIGHT = 8'd192;

   localparam logic [1:0] CODE_BLACK = 2'd0;
   localparam logic [1:0] CODE_DARK  = 2'd3;
   localparam logic [1:0] CODE_LIGHT = 2'd2;
   localparam logic [1:0] CODE_WHITE = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_LEFT   = 2'd0,
      CSR_AREA_TOP    = 2'd1,
      CSR_AREA_RIGHT  = 2'd2,
      CSR_AREA_BOTTOM = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              mode;
      logic [PIXEL_W-1:0] pixel;
      logic              restart;
      logic [RIDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              clipped;
      logic              area_done;
   } rsp_type;

   // one classified item on its way from front to back
   typedef struct packed {
      logic              mode;
      logic [PIXEL_W-1:0] pixel;
      logic              wr_en;
      logic [1:0]        slot;
      logic              clipped;
      logic              area_done;
      logic              rd_ok;
   } work_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [12:0] prod;
      logic [28:0] scaled;
      prod   = (13'(v) << 8) - 13'(v);
      scaled = 29'(prod) * 29'(RECIP31);
      return scaled[27:20];
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [13:0] prod;
      logic [29:0] scaled;
      prod   = (14'(v) << 8) - 14'(v);
      scaled = 30'(prod) * 30'(RECIP63);
      return scaled[27:20];
   endfunction

   function automatic logic [1:0] luma_code(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
      logic [15:0] sum;
      logic [7:0]  y;
      sum = 16'(r) * 16'd77 + 16'(g) * 16'd150 + 16'(b) * 16'd29;
      y   = sum[15:8];
      if (y < LUMA_DARK) begin
         return CODE_BLACK;
      end else if (y < LUMA_MID) begin
         return CODE_DARK;
      end else if (y < LUMA_LIGHT) begin
         return CODE_LIGHT;
      end
      return CODE_WHITE;
   endfunction

endpackage

// ----- sv/r2f_front.sv -----
// Front end: area registers, cursor walk, clipping and frame address.
// Classifies each accepted item and pushes it to the queue. Uses r2f_pkg.
module r2f_front #(
   parameter int PANEL_WIDTH  = r2f_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = r2f_pkg::PANEL_HEIGHT_DEF,
   parameter int ADDR_W       = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [r2f_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [r2f_pkg::COORD_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  r2f_pkg::req_type                req_payload,
   input  logic                            q_full,
   input  logic                            clear_busy,
   output logic                            push,
   output r2f_pkg::work_type               push_work,
   output logic [ADDR_W-1:0]               push_addr
);

   localparam int FRAME_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4;
   localparam int PROD_W      = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
   localparam int COL_W       = $clog2(PANEL_WIDTH);
   localparam int ROW_W       = $clog2(PANEL_HEIGHT + 1);
   localparam logic signed [r2f_pkg::COORD_W-1:0] WIDTH_S  = r2f_pkg::COORD_W'(PANEL_WIDTH);
   localparam logic signed [r2f_pkg::COORD_W-1:0] HEIGHT_S = r2f_pkg::COORD_W'(PANEL_HEIGHT);

   logic signed [r2f_pkg::COORD_W-1:0] left_ff, left_in, top_ff, top_in;
   logic signed [r2f_pkg::COORD_W-1:0] right_ff, right_in, bottom_ff, bottom_in;
   logic signed [r2f_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [r2f_pkg::COORD_W-1:0] col_eff, row_eff;
   logic                               fire, in_disp, end_row, end_area;
   logic [COL_W-1:0]                   col_u;
   logic [ROW_W-1:0]                   row_u;
   logic [PROD_W-1:0]                  row_base;
   logic [ADDR_W-1:0]                  pix_addr;

   assign req_ready = !q_full && !clear_busy;
   assign fire      = req_valid && req_ready;
   assign push      = fire;

   assign col_eff  = req_payload.restart ? left_ff : col_ff;
   assign row_eff  = req_payload.restart ? top_ff : row_ff;
   assign in_disp  = !col_eff[r2f_pkg::COORD_W-1] && (col_eff < WIDTH_S) &&
                     !row_eff[r2f_pkg::COORD_W-1] && (row_eff < HEIGHT_S);
   assign end_row  = col_eff >= right_ff;
   assign end_area = end_row && (row_eff >= bottom_ff);

   assign col_u    = COL_W'(col_eff);
   assign row_u    = ROW_W'(row_eff);
   assign row_base = PROD_W'(row_u) * PROD_W'(PANEL_WIDTH);
   assign pix_addr = ADDR_W'(row_base >> 2) + ADDR_W'(col_u >> 2);

   always_comb begin
      push_work.mode      = req_payload.mode;
      push_work.pixel     = req_payload.pixel;
      push_work.wr_en     = !req_payload.mode && in_disp;
      push_work.slot      = col_eff[1:0];
      push_work.clipped   = !req_payload.mode && !in_disp;
      push_work.area_done = !req_payload.mode && end_area;
      push_work.rd_ok     = req_payload.mode &&
                            (32'(req_payload.read_index) < 32'(FRAME_BYTES));
      push_addr = req_payload.mode ? ADDR_W'(req_payload.read_index) : pix_addr;
   end

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (csr_we) begin
         unique case (r2f_pkg::csr_index_type'(csr_index))
            r2f_pkg::CSR_AREA_LEFT:   left_in   = csr_wdata;
            r2f_pkg::CSR_AREA_TOP:    top_in    = csr_wdata;
            r2f_pkg::CSR_AREA_RIGHT:  right_in  = csr_wdata;
            r2f_pkg::CSR_AREA_BOTTOM: bottom_in = csr_wdata;
            default:                  left_in   = left_ff;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (fire && !req_payload.mode) begin
         if (end_row) begin
            col_in = left_ff;
            row_in = end_area ? top_ff : row_eff + 12'sd1;
         end else begin
            col_in = col_eff + 12'sd1;
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= r2f_pkg::AREA_LEFT_RST;
         top_ff    <= r2f_pkg::AREA_TOP_RST;
         right_ff  <= r2f_pkg::AREA_RIGHT_RST;
         bottom_ff <= r2f_pkg::AREA_BOTTOM_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- sv/r2f_queue.sv -----
// Small FIFO between front and back end.
// Generic data width; no package dependency.
module r2f_queue #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/r2f_back.sv -----
// Back end: frame store with clearing pass, read-modify-write with bypass,
// color conversion and the result register. Uses r2f_pkg.
module r2f_back #(
   parameter int PANEL_WIDTH  = r2f_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = r2f_pkg::PANEL_HEIGHT_DEF,
   parameter int ADDR_W       = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  r2f_pkg::work_type   head_work,
   input  logic [ADDR_W-1:0]   head_addr,
   output logic                pop,
   output logic                clear_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output r2f_pkg::rsp_type    rsp_payload
);

   localparam int FRAME_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4;

   logic [r2f_pkg::BYTE_W-1:0] frame_mem [FRAME_BYTES];

   logic                       clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]          clear_addr_ff, clear_addr_in;
   logic                       s1_valid_ff, s1_valid_in;
   r2f_pkg::work_type          s1_work_ff;
   logic [ADDR_W-1:0]          s1_addr_ff;
   logic [7:0]                 s1_r_ff, s1_g_ff, s1_b_ff;
   logic                       byp_valid_ff, byp_valid_in;
   logic [r2f_pkg::BYTE_W-1:0] byp_data_ff, byp_data_in;
   logic [r2f_pkg::BYTE_W-1:0] rdata_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   r2f_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       s1_go, rd_en, s1_wr, mem_we;
   logic [1:0]                 code;
   logic [r2f_pkg::BYTE_W-1:0] old_byte, new_byte, mem_wdata;
   logic [ADDR_W-1:0]          mem_waddr;

   assign clear_busy  = clear_busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign s1_go = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop   = head_valid && !clear_busy_ff && (!s1_valid_ff || s1_go);
   assign rd_en = pop && ((head_work.mode && head_work.rd_ok) || head_work.wr_en);

   assign old_byte = byp_valid_ff ? byp_data_ff : rdata_ff;
   assign code     = r2f_pkg::luma_code(s1_r_ff, s1_g_ff, s1_b_ff);
   assign s1_wr    = s1_go && s1_work_ff.wr_en;

   always_comb begin
      case (s1_work_ff.slot)
         2'd0:    new_byte = {code, old_byte[5:0]};
         2'd1:    new_byte = {old_byte[7:6], code, old_byte[3:0]};
         2'd2:    new_byte = {old_byte[7:4], code, old_byte[1:0]};
         default: new_byte = {old_byte[7:2], code};
      endcase
   end

   always_comb begin
      mem_we    = clear_busy_ff || s1_wr;
      mem_waddr = clear_busy_ff ? clear_addr_ff : s1_addr_ff;
      mem_wdata = clear_busy_ff ? r2f_pkg::WHITE_BYTE : new_byte;
   end

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(FRAME_BYTES - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   // the byte written in the cycle of a read is not seen by that read
   always_comb begin
      byp_valid_in = byp_valid_ff;
      byp_data_in  = byp_data_ff;
      if (pop) begin
         byp_valid_in = s1_wr && (s1_addr_ff == head_addr);
         byp_data_in  = new_byte;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in.read_data   = (s1_work_ff.mode && s1_work_ff.rd_ok) ? old_byte : '0;
         rsp_in.clipped     = s1_work_ff.clipped;
         rsp_in.area_done   = s1_work_ff.area_done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         byp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         byp_valid_ff  <= byp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      rsp_ff      <= rsp_in;
      if (pop) begin
         s1_work_ff <= head_work;
         s1_addr_ff <= head_addr;
         s1_r_ff    <= r2f_pkg::widen5(head_work.pixel[15:11]);
         s1_g_ff    <= r2f_pkg::widen6(head_work.pixel[10:5]);
         s1_b_ff    <= r2f_pkg::widen5(head_work.pixel[4:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= frame_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
   end

endmodule

// ----- sv/rgb565_to_2bpp_frame_writer.sv -----
// Top level of the RGB565 to 2bpp frame writer.
// Instantiates r2f_front, r2f_queue and r2f_back; uses r2f_pkg.
//
//   channel   ports                           direction   transfer
//   req       req_valid req_ready req_payload in          valid & ready
//   rsp       rsp_valid rsp_ready rsp_payload out         valid & ready
//   csr       csr_we csr_index csr_wdata      in          csr_we
//
// One item per clock sustained while rsp_ready is high and no clearing pass runs;
// a result passes through the queue, the registered frame store read and the
// result register. After reset a clearing pass writes 0x55 to every frame byte,
// (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4 bytes (30000 at default), one byte per cycle,
// with req_ready low. A stalled rsp fills the 4-entry queue, then req_ready drops.
module rgb565_to_2bpp_frame_writer #(
   parameter int PANEL_WIDTH  = r2f_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = r2f_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [r2f_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [r2f_pkg::COORD_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  r2f_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output r2f_pkg::rsp_type              rsp_payload
);

   localparam int FRAME_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 3) / 4;
   localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int WORK_W      = $bits(r2f_pkg::work_type);
   localparam int QDATA_W     = WORK_W + ADDR_W;

   logic                 push, q_full, q_not_empty, pop, clear_busy;
   r2f_pkg::work_type    push_work, head_work;
   logic [ADDR_W-1:0]    push_addr, head_addr;
   logic [QDATA_W-1:0]   q_head;

   r2f_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .push       (push),
      .push_work  (push_work),
      .push_addr  (push_addr)
   );

   r2f_queue #(
      .DATA_W(QDATA_W),
      .DEPTH (r2f_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_work, push_addr}),
      .full     (q_full),
      .pop      (pop),
      .not_empty(q_not_empty),
      .head_data(q_head)
   );

   assign head_work = r2f_pkg::work_type'(q_head[QDATA_W-1:ADDR_W]);
   assign head_addr = q_head[ADDR_W-1:0];

   r2f_back #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head_work  (head_work),
      .head_addr  (head_addr),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("req transfer possible during clearing pass");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> clear_busy)
      else $error("clearing pass not started after reset");

   a_read_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.read_data != 8'd0) |->
         !rsp_payload.clipped && !rsp_payload.area_done)
      else $error("read result carries write flags");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !pop |=> !push || q_full)
      else $error("queue lost its full state without a pop");

endmodule
